>>> hdl/json_string_unescape_utf8_unit_defines.svh
// assertion macros shared by the json string unescape unit
// depends on nothing; clocked on clk_i and disabled while rst_ni is low
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define JSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("jsu assertion failed");
`define JSU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("jsu forbidden condition seen");
`else
`define JSU_ASSERT(lbl, prop)
`define JSU_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> hdl/jsu_pkg.sv
// types, constants and helper functions of the json string unescape unit
// used by the front parser, the group queue and the back serialiser
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_WAIT      = 3'd0,
    MODE_STRING    = 3'd1,
    MODE_ESCAPE    = 3'd2,
    MODE_HEX_HIGH  = 3'd3,
    MODE_AFTER_HI  = 3'd4,
    MODE_HI_ESCAPE = 3'd5,
    MODE_HEX_LOW   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_CLOSED    = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_e;

  localparam int unsigned GroupMax = 4;
  localparam int unsigned GroupCntW = $clog2(GroupMax + 1);
  localparam int unsigned GroupIdxW = $clog2(GroupMax);
  localparam int unsigned GqDepth = 4;
  localparam int unsigned GqPtrW = $clog2(GqDepth);
  localparam int unsigned GqCntW = $clog2(GqDepth + 1);

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChLf        = 8'h0a;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [5:0] HighSurTag  = 6'b110110;
  localparam logic [5:0] LowSurTag   = 6'b110111;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } item_t;

  // all results caused by one input byte, oldest in items[0]
  typedef struct packed {
    logic [GroupCntW-1:0]         cnt;
    item_t [GroupMax-1:0]         items;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } gq_head_t;

  function automatic group_t group_add(group_t g, logic [7:0] d, kind_e k);
    group_t r;
    r = g;
    if (g.cnt < GroupCntW'(GroupMax)) begin
      r.items[g.cnt[GroupIdxW-1:0]].data = d;
      r.items[g.cnt[GroupIdxW-1:0]].kind = k;
      r.cnt = g.cnt + GroupCntW'(1);
    end
    return r;
  endfunction

  function automatic group_t utf8_encode(logic [20:0] cp);
    group_t g;
    g = '0;
    if (cp <= 21'h7f) begin
      g = group_add(g, cp[7:0], KIND_DATA);
    end else if (cp <= 21'h7ff) begin
      g = group_add(g, {3'b110, cp[10:6]}, KIND_DATA);
      g = group_add(g, {2'b10, cp[5:0]}, KIND_DATA);
    end else if (cp <= 21'hffff) begin
      g = group_add(g, {4'b1110, cp[15:12]}, KIND_DATA);
      g = group_add(g, {2'b10, cp[11:6]}, KIND_DATA);
      g = group_add(g, {2'b10, cp[5:0]}, KIND_DATA);
    end else begin
      g = group_add(g, {5'b11110, cp[20:18]}, KIND_DATA);
      g = group_add(g, {2'b10, cp[17:12]}, KIND_DATA);
      g = group_add(g, {2'b10, cp[11:6]}, KIND_DATA);
      g = group_add(g, {2'b10, cp[5:0]}, KIND_DATA);
    end
    return g;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {valid, decoded byte}
  function automatic logic [8:0] simple_escape(logic [7:0] b);
    logic [8:0] r;
    case (b)
      ChQuote:     r = {1'b1, ChQuote};
      ChBackslash: r = {1'b1, ChBackslash};
      ChSlash:     r = {1'b1, ChSlash};
      8'h62:       r = {1'b1, 8'h08};
      8'h66:       r = {1'b1, 8'h0c};
      8'h6e:       r = {1'b1, ChLf};
      8'h72:       r = {1'b1, ChCr};
      8'h74:       r = {1'b1, ChTab};
      default:     r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/jsu_front.sv
// front parser: takes one byte per transaction and turns it into a group of results
// depends on jsu_pkg; feeds jsu_gq
module jsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_text_i,
  output logic            gq_push_o,
  output jsu_pkg::group_t gq_grp_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [15:0]    hex_q, hex_d;
  logic [1:0]     dig_q, dig_d;
  logic [9:0]     pend_q, pend_d;

  logic            accept;
  logic [4:0]      hx;
  logic [8:0]      esc;
  logic [15:0]     hex_new;
  logic [20:0]     lone_cp;
  logic [20:0]     pair_cp;
  logic            do_fail;
  logic            do_close;
  jsu_pkg::group_t grp;

  assign accept  = push_i && !full_i;
  assign hx      = jsu_pkg::hex_digit(in_byte_i);
  assign esc     = jsu_pkg::simple_escape(in_byte_i);
  assign hex_new = {hex_q[11:0], hx[3:0]};
  assign lone_cp = {5'b0, jsu_pkg::HighSurTag, pend_q};
  assign pair_cp = 21'h10000 + {1'b0, pend_q, hex_new[9:0]};

  always_comb begin
    mode_d   = mode_q;
    hex_d    = hex_q;
    dig_d    = dig_q;
    pend_d   = pend_q;
    grp      = '0;
    do_fail  = 1'b0;
    do_close = 1'b0;
    if (end_of_text_i) begin
      do_fail = 1'b1;
    end else begin
      case (mode_q)
        jsu_pkg::MODE_STRING: begin
          if (in_byte_i == jsu_pkg::ChQuote) begin
            do_close = 1'b1;
          end else if (in_byte_i == jsu_pkg::ChBackslash) begin
            mode_d = jsu_pkg::MODE_ESCAPE;
          end else begin
            grp = jsu_pkg::group_add(grp, in_byte_i, jsu_pkg::KIND_DATA);
          end
        end
        jsu_pkg::MODE_ESCAPE, jsu_pkg::MODE_HI_ESCAPE: begin
          if (in_byte_i == jsu_pkg::ChU) begin
            mode_d = (mode_q == jsu_pkg::MODE_ESCAPE) ? jsu_pkg::MODE_HEX_HIGH
                                                      : jsu_pkg::MODE_HEX_LOW;
            hex_d  = '0;
            dig_d  = '0;
          end else begin
            // a pending high surrogate goes out on its own first
            if (mode_q == jsu_pkg::MODE_HI_ESCAPE) begin
              grp = jsu_pkg::utf8_encode(lone_cp);
            end
            if (esc[8]) begin
              grp    = jsu_pkg::group_add(grp, esc[7:0], jsu_pkg::KIND_DATA);
              mode_d = jsu_pkg::MODE_STRING;
            end else begin
              do_fail = 1'b1;
            end
          end
        end
        jsu_pkg::MODE_HEX_HIGH, jsu_pkg::MODE_HEX_LOW: begin
          if (!hx[4]) begin
            do_fail = 1'b1;
          end else if (dig_q != 2'd3) begin
            hex_d = hex_new;
            dig_d = dig_q + 2'd1;
          end else begin
            hex_d = hex_new;
            if (mode_q == jsu_pkg::MODE_HEX_HIGH) begin
              if (hex_new[15:10] == jsu_pkg::HighSurTag) begin
                pend_d = hex_new[9:0];
                mode_d = jsu_pkg::MODE_AFTER_HI;
              end else begin
                grp    = jsu_pkg::utf8_encode({5'b0, hex_new});
                mode_d = jsu_pkg::MODE_STRING;
              end
            end else if (hex_new[15:10] == jsu_pkg::LowSurTag) begin
              grp    = jsu_pkg::utf8_encode(pair_cp);
              mode_d = jsu_pkg::MODE_STRING;
            end else begin
              do_fail = 1'b1;
            end
          end
        end
        jsu_pkg::MODE_AFTER_HI: begin
          if (in_byte_i == jsu_pkg::ChBackslash) begin
            mode_d = jsu_pkg::MODE_HI_ESCAPE;
          end else begin
            grp = jsu_pkg::utf8_encode(lone_cp);
            if (in_byte_i == jsu_pkg::ChQuote) begin
              do_close = 1'b1;
            end else begin
              grp    = jsu_pkg::group_add(grp, in_byte_i, jsu_pkg::KIND_DATA);
              mode_d = jsu_pkg::MODE_STRING;
            end
          end
        end
        default: begin
          mode_d = jsu_pkg::MODE_WAIT;
          hex_d  = '0;
          dig_d  = '0;
          pend_d = '0;
          if (in_byte_i == jsu_pkg::ChQuote) begin
            mode_d = jsu_pkg::MODE_STRING;
          end else if (!(in_byte_i == jsu_pkg::ChSpace || in_byte_i == jsu_pkg::ChTab ||
                         in_byte_i == jsu_pkg::ChCr || in_byte_i == jsu_pkg::ChLf)) begin
            do_fail = 1'b1;
          end
        end
      endcase
    end
    // closing and failing both end the string and come last in the group
    if (do_fail || do_close) begin
      grp    = jsu_pkg::group_add(grp, 8'h00,
                                  do_fail ? jsu_pkg::KIND_MALFORMED : jsu_pkg::KIND_CLOSED);
      mode_d = jsu_pkg::MODE_WAIT;
      hex_d  = '0;
      dig_d  = '0;
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_WAIT;
      hex_q  <= '0;
      dig_q  <= '0;
      pend_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      dig_q  <= dig_d;
      pend_q <= pend_d;
    end
  end

  assign gq_push_o = accept && (grp.cnt != '0);
  assign gq_grp_o  = grp;

endmodule

>>> hdl/jsu_gq.sv
// short queue of result groups between the front parser and the back serialiser
// depends on jsu_pkg and the assertion macro header
`include "json_string_unescape_utf8_unit_defines.svh"
module jsu_gq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jsu_pkg::group_t   grp_i,
  output logic              full_o,
  input  logic              pop_i,
  output jsu_pkg::gq_head_t head_o
);

  jsu_pkg::group_t                mem_q [jsu_pkg::GqDepth];
  logic [jsu_pkg::GqPtrW-1:0]     wr_q, wr_d;
  logic [jsu_pkg::GqPtrW-1:0]     rd_q, rd_d;
  logic [jsu_pkg::GqCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push;
  logic                           do_pop;

  assign full_o       = (cnt_q == jsu_pkg::GqCntW'(jsu_pkg::GqDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.grp   = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_d  = do_push ? wr_q + jsu_pkg::GqPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + jsu_pkg::GqPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + jsu_pkg::GqCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - jsu_pkg::GqCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= grp_i;
    end
  end

  `JSU_ASSERT(a_cnt_bound, cnt_q <= jsu_pkg::GqCntW'(jsu_pkg::GqDepth))
  `JSU_ASSERT_NEVER(a_push_when_full, push_i && full_o)
  `JSU_ASSERT_NEVER(a_pop_when_empty, pop_i && !head_o.valid)
  `JSU_ASSERT(a_no_empty_group, push_i |-> grp_i.cnt != '0)
  `JSU_ASSERT(a_ptr_track, head_o.valid && !full_o |-> wr_q != rd_q)

endmodule

>>> hdl/jsu_back.sv
// back serialiser: emits the results of each queued group one per transaction
// depends on jsu_pkg and the assertion macro header
`include "json_string_unescape_utf8_unit_defines.svh"
module jsu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jsu_pkg::gq_head_t head_i,
  output logic              gq_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        kind_o,
  output logic              last_o
);

  logic [jsu_pkg::GroupIdxW-1:0] idx_q, idx_d;
  logic                          valid_q, valid_d;
  jsu_pkg::item_t                item_q, item_d;
  logic                          last_q, last_d;
  logic                          load;
  logic                          is_last;

  assign load    = head_i.valid && (!valid_q || pop_i);
  assign is_last = ({1'b0, idx_q} == head_i.grp.cnt - jsu_pkg::GroupCntW'(1));

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !pop_i;
    item_d  = item_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = head_i.grp.items[idx_q];
      last_d  = is_last;
      idx_d   = is_last ? '0 : idx_q + jsu_pkg::GroupIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload needs no reset, qualified by valid_q
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    last_q <= last_d;
  end

  assign gq_pop_o   = load && is_last;
  assign empty_o    = !valid_q;
  assign out_byte_o = item_q.data;
  assign kind_o     = item_q.kind;
  assign last_o     = last_q;

  `JSU_ASSERT(a_idx_in_group, head_i.valid |-> {1'b0, idx_q} < head_i.grp.cnt)
  `JSU_ASSERT(a_idx_needs_head, idx_q != '0 |-> head_i.valid)
  `JSU_ASSERT(a_data_byte_only, valid_q && item_q.kind != jsu_pkg::KIND_DATA |->
              item_q.data == 8'h00 && last_q)

endmodule

>>> hdl/json_string_unescape_utf8_unit.sv
// Top level of the json string unescape unit: decodes json string literals into UTF-8.
// Input channel: push/full, one raw byte (or an end of text mark) per transaction.
// Result channel: empty/pop; out_byte_o, kind_o (0 data, 1 string closed,
// 2 malformed) and last_o (final result caused by that input byte) of the oldest result.
// Each input byte causes zero to four results; last_o marks the end of each burst.
// A result is written into the group queue when its byte is taken and reaches the ports
// from the back serialiser's output register, when nothing is waiting ahead of it.
// Throughput: while pop is high, one byte per cycle if each causes at most one result;
// the back serialiser then sends one result per cycle, holding a byte until all are sent.
// A four-entry group queue between the parser and the serialiser absorbs such bursts;
// full rises only when that queue holds four groups.
// When the receiver stalls (pop low) the output register holds its result, the group
// queue fills and full then stops the input side; nothing is dropped.
// Reset empties the group queue and the output register and returns the parser to
// waiting for an opening quote; no clearing pass is needed.
// depends on jsu_pkg, jsu_front, jsu_gq, jsu_back
module json_string_unescape_utf8_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  logic              gq_push;
  jsu_pkg::group_t   gq_grp;
  logic              gq_full;
  logic              gq_pop;
  jsu_pkg::gq_head_t gq_head;

  assign full = gq_full;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (gq_full),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .gq_push_o     (gq_push),
    .gq_grp_o      (gq_grp)
  );

  jsu_gq u_gq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (gq_push),
    .grp_i  (gq_grp),
    .full_o (gq_full),
    .pop_i  (gq_pop),
    .head_o (gq_head)
  );

  jsu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (gq_head),
    .gq_pop_o   (gq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o),
    .last_o     (last_o)
  );

endmodule
